>>> rtl/core/cdps_pkg.sv
// cdps_pkg: types, widths and command codes for the point-set distance block
// depends on nothing; imported by cdps_isqrt, closest_distance_between_point_sets and tb
package cdps_pkg;

    // field widths
    localparam int COORD_W    = 20;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int SQ_W       = PROD_W + 2;
    localparam int ROOT_W     = SQ_W / 2;
    localparam int DIST_W     = 21;
    localparam int CMD_W      = 2;

    // default store depth
    localparam int MAX_POINTS_DEF = 1024;

    // command codes
    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PROBE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FINISH = 2'd2;

    // one input transfer
    typedef struct packed {
        logic        [CMD_W-1:0]   command;
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
        logic signed [COORD_W-1:0] z_coord;
    } item_t;

    // one result transfer
    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              found;
        logic              overflow;
    } result_t;

    // one stored first-set point
    typedef struct packed {
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
        logic signed [COORD_W-1:0] z_coord;
    } point_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_ROOT,
        ST_EMIT
    } state_t;

endpackage

>>> rtl/core/cdps_ram.sv
// cdps_ram: generic single-port-write, single-port-read RAM with registered read
// depends on nothing
module cdps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/cdps_isqrt.sv
// cdps_isqrt: floor square root, one result bit per cycle (restoring digit recurrence)
// depends on cdps_pkg for SQ_W and ROOT_W
module cdps_isqrt
    import cdps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SQ_W-1:0]   value,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    localparam int STEP_W = $clog2(ROOT_W);
    localparam int REM_W  = ROOT_W + 1;

    logic [SQ_W-1:0]   val_reg,  val_next;
    logic [REM_W-1:0]  rem_reg,  rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [REM_W+1:0]  rem_shift;
    logic [REM_W+1:0]  trial;

    // bring down two bits and try the next root bit
    assign rem_shift = {rem_reg, val_reg[SQ_W-1 -: 2]};
    assign trial     = {1'b0, root_reg, 2'b01};

    always_comb
    begin
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            val_next  = value;
            rem_next  = '0;
            root_next = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            val_next  = {val_reg[SQ_W-3:0], 2'b00};
            step_next = step_reg + 1'b1;
            if (rem_shift >= trial)
            begin
                rem_next  = REM_W'(rem_shift - trial);
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = REM_W'(rem_shift);
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            if (step_reg == STEP_W'(ROOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

>>> rtl/core/closest_distance_between_point_sets.sv
// closest_distance_between_point_sets: brute-force minimum distance between two 3D point sets
// depends on cdps_pkg, cdps_ram (point store) and cdps_isqrt (final root)
//
//  channel  | valid        | stall        | payload        | direction
//  ---------+--------------+--------------+----------------+----------
//  item     | item_valid   | item_stall   | item (item_t)  | in
//  result   | result_valid | result_stall | result         | out
//
// a load is written into the store when it is accepted; a second-set point is swept
// by one store read per cycle feeding a three-stage distance pipeline, and a finish
// waits on the bit-per-cycle root unit and then on the output register.
// item_stall is high whenever the sequencer is not idle; a waiting result
// holds in the output register while loads and points keep coming in.
// reset clears the count and flags and sets the best distance to all ones; the store needs no clearing.
module closest_distance_between_point_sets
    import cdps_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam logic [ROOT_W-1:0] DIST_MAX = ROOT_W'((64'd1 << DIST_W) - 64'd1);

    // absolute difference of two coordinates
    function automatic logic [DIFF_W-1:0] abs_diff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [DIFF_W-1:0] d;
        begin
            d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
            abs_diff = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
        end
    endfunction

    state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic [SQ_W-1:0]  best_reg, best_next;
    logic             seen_reg, seen_next;
    logic             dropped_reg, dropped_next;

    logic             s0_valid_reg, s1_valid_reg, s2_valid_reg;

    point_t           cand_reg;
    logic [DIFF_W-1:0] dx_reg, dy_reg, dz_reg;
    logic [PROD_W-1:0] sqx_reg, sqy_reg, sqz_reg;
    logic [SQ_W-1:0]   sum;

    result_t          result_reg, result_next;
    logic             result_valid_reg, result_valid_next;

    logic             accept;
    logic             wr_en;
    logic             rd_en;
    logic             root_start;
    logic             out_load;
    logic             root_done;
    logic [ROOT_W-1:0] root;
    point_t           rd_point;
    point_t           wr_point;
    logic [DIST_W-1:0] dist_sat;

    assign accept     = item_valid && !item_stall;
    assign item_stall = (state_reg != ST_IDLE);

    // point store
    assign wr_point = '{x_coord: item.x_coord, y_coord: item.y_coord, z_coord: item.z_coord};

    cdps_ram #(
        .WIDTH ($bits(point_t)),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (wr_point),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg[ADDR_W-1:0]),
        .rd_data (rd_point)
    );

    // root unit for the finish
    cdps_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (root_start),
        .value (best_reg),
        .done  (root_done),
        .root  (root)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (item.command)
                        CMD_PROBE:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = ST_SWEEP;
                            end
                        end
                        CMD_FINISH:
                        begin
                            state_next = ST_ROOT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SWEEP:
            begin
                if (rd_idx_reg + 1'b1 == count_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!s0_valid_reg && !s1_valid_reg && !s2_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ROOT:
            begin
                if (root_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        root_start = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                wr_en = accept && (item.command == CMD_LOAD)
                        && (count_reg < CNT_W'(MAX_POINTS));
                root_start = accept && (item.command == CMD_FINISH);
            end
            ST_SWEEP:
            begin
                rd_en = 1'b1;
            end
            ST_EMIT:
            begin
                out_load = !result_valid_reg || !result_stall;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // squared distance of the pair leaving the pipeline
    assign sum = SQ_W'(sqx_reg) + SQ_W'(sqy_reg) + SQ_W'(sqz_reg);

    // count, best distance and flags
    always_comb
    begin
        count_next   = count_reg;
        best_next    = best_reg;
        seen_next    = seen_reg;
        dropped_next = dropped_reg;
        rd_idx_next  = rd_idx_reg;
        if (state_reg == ST_IDLE && accept && item.command == CMD_LOAD)
        begin
            if (count_reg < CNT_W'(MAX_POINTS))
            begin
                count_next = count_reg + 1'b1;
            end
            else
            begin
                dropped_next = 1'b1;
            end
        end
        if (state_reg == ST_IDLE && accept && item.command == CMD_PROBE)
        begin
            rd_idx_next = '0;
            if (count_reg != '0)
            begin
                seen_next = 1'b1;
            end
        end
        if (rd_en)
        begin
            rd_idx_next = rd_idx_reg + 1'b1;
        end
        if (s2_valid_reg && (sum < best_reg))
        begin
            best_next = sum;
        end
        if (out_load)
        begin
            count_next   = '0;
            best_next    = '1;
            seen_next    = 1'b0;
            dropped_next = 1'b0;
        end
    end

    // saturate the root to the distance width
    assign dist_sat = (root > DIST_MAX) ? DIST_MAX[DIST_W-1:0] : root[DIST_W-1:0];

    // output register
    always_comb
    begin
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
        if (out_load)
        begin
            result_next.distance = seen_reg ? dist_sat : '0;
            result_next.found    = seen_reg;
            result_next.overflow = dropped_reg;
            result_valid_next    = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            rd_idx_reg       <= '0;
            best_reg         <= '1;
            seen_reg         <= 1'b0;
            dropped_reg      <= 1'b0;
            s0_valid_reg     <= 1'b0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            rd_idx_reg       <= rd_idx_next;
            best_reg         <= best_next;
            seen_reg         <= seen_next;
            dropped_reg      <= dropped_next;
            s0_valid_reg     <= rd_en;
            s1_valid_reg     <= s0_valid_reg;
            s2_valid_reg     <= s1_valid_reg;
            result_valid_reg <= result_valid_next;
        end
    end

    // candidate point, differences, squares and result payload
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && accept && item.command == CMD_PROBE)
        begin
            cand_reg <= wr_point;
        end
        if (s0_valid_reg)
        begin
            dx_reg <= abs_diff(rd_point.x_coord, cand_reg.x_coord);
            dy_reg <= abs_diff(rd_point.y_coord, cand_reg.y_coord);
            dz_reg <= abs_diff(rd_point.z_coord, cand_reg.z_coord);
        end
        if (s1_valid_reg)
        begin
            sqx_reg <= dx_reg * dx_reg;
            sqy_reg <= dy_reg * dy_reg;
            sqz_reg <= dz_reg * dz_reg;
        end
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

>>> bench/tb.sv
// tb: self-checking bench for closest_distance_between_point_sets
// depends on cdps_pkg and the block's RTL; predicts every result and checks it on the fly
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cdps_pkg::*;

    localparam int MAX_PTS       = MAX_POINTS_DEF;
    localparam int RANDOM_ITEMS  = 580;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = MAX_PTS + 80;
    localparam int IDLE_LIMIT    = 8000;

    // unused command code, the block ignores it
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    localparam logic [63:0] SQ_MAX     = (64'd1 << 44) - 64'd1;
    localparam logic [63:0] DIST_MAX   = (64'd1 << DIST_W) - 64'd1;
    localparam longint      DIFF_LIMIT = 64'sd1 << 22;

    // one queued transfer, or a pause marker that waits for all results
    typedef struct packed {
        logic  pause;
        item_t payload;
    } stim_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    stim_t   stim_queue[$];
    result_t pending_distances[$];
    int      queued_count = 0;
    int      mismatches = 0;

    // predictor state
    point_t      model_points [MAX_PTS];
    int unsigned model_count = 0;
    logic [63:0] model_best = SQ_MAX;
    bit          model_seen = 1'b0;
    bit          model_dropped = 1'b0;

    // driver, receiver and watchdog private counters
    int burst_left = 1;
    int gap_left = 0;
    int rx_seen = 0;
    int holds_done = 0;
    int hold_left = 0;
    int stall_mode = 0;
    int phase_left = 0;
    int idle_cycles = 0;

    closest_distance_between_point_sets #(
        .MAX_POINTS (MAX_PTS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // squared coordinate gap, saturating at SQ_MAX
    function automatic logic [63:0] squared_gap(longint a, longint b);
        longint d;
        d = a - b;
        if (d < 0)
            d = -d;
        if (d >= DIFF_LIMIT)
            return SQ_MAX;
        return 64'(d * d);
    endfunction

    // floor square root, one bit per step
    function automatic logic [63:0] floor_root(logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        int          b;
        root = '0;
        for (b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    // track the block's state for one accepted transfer
    task automatic predict_distance(item_t it);
        logic [63:0] sq;
        logic [63:0] root;
        result_t     r;
        int unsigned i;
        case (it.command)
            CMD_LOAD:
            begin
                if (model_count < MAX_PTS)
                begin
                    model_points[model_count].x_coord = it.x_coord;
                    model_points[model_count].y_coord = it.y_coord;
                    model_points[model_count].z_coord = it.z_coord;
                    model_count++;
                end
                else
                    model_dropped = 1'b1;
            end
            CMD_PROBE:
            begin
                for (i = 0; i < model_count; i++)
                begin
                    sq = squared_gap(model_points[i].x_coord, it.x_coord)
                       + squared_gap(model_points[i].y_coord, it.y_coord);
                    if (sq > SQ_MAX)
                        sq = SQ_MAX;
                    sq = sq + squared_gap(model_points[i].z_coord, it.z_coord);
                    if (sq > SQ_MAX)
                        sq = SQ_MAX;
                    if (sq < model_best)
                        model_best = sq;
                    model_seen = 1'b1;
                end
            end
            CMD_FINISH:
            begin
                r = '0;
                if (model_seen)
                begin
                    root = floor_root(model_best);
                    if (root > DIST_MAX)
                        root = DIST_MAX;
                    r.distance = root[DIST_W-1:0];
                end
                r.found = model_seen;
                r.overflow = model_dropped;
                pending_distances.push_back(r);
                model_count = 0;
                model_best = SQ_MAX;
                model_seen = 1'b0;
                model_dropped = 1'b0;
            end
            default: ;
        endcase
    endtask

    task automatic queue_item(logic [CMD_W-1:0] cmd, logic signed [COORD_W-1:0] x,
                              logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z);
        stim_t s;
        s.pause = 1'b0;
        s.payload.command = cmd;
        s.payload.x_coord = x;
        s.payload.y_coord = y;
        s.payload.z_coord = z;
        stim_queue.push_back(s);
        if (cmd != CMD_SPARE)
            queued_count++;
    endtask

    task automatic queue_pause();
        stim_t s;
        s = '0;
        s.pause = 1'b1;
        stim_queue.push_back(s);
    endtask

    // coordinate near a centre, at an extreme, or anywhere
    function automatic logic signed [COORD_W-1:0] pick_coord(logic signed [COORD_W-1:0] centre);
        logic signed [COORD_W-1:0] off;
        int unsigned               sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return '0;
            3, 4, 5:
            begin
                off = COORD_W'($urandom_range(0, 1023));
                return centre + off - 20'sd512;
            end
            6:
            begin
                off = COORD_W'($urandom_range(0, 65535));
                return centre + off - 20'sd32768;
            end
            default:
            begin
                off = COORD_W'($urandom);
                return off;
            end
        endcase
    endfunction

    // one well-formed set with random content, sometimes broken
    task automatic queue_random_set();
        int unsigned               n_load;
        int unsigned               n_probe;
        int unsigned               roll;
        bit                        mixed;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        cx = pick_coord('0);
        cy = pick_coord('0);
        cz = pick_coord('0);
        roll = $urandom_range(0, 9);
        n_load = (roll < 7) ? $urandom_range(1, 6) : (roll < 9) ? $urandom_range(7, 30) : 0;
        roll = $urandom_range(0, 9);
        n_probe = (roll < 8) ? $urandom_range(1, 5) : (roll < 9) ? $urandom_range(6, 12) : 0;
        mixed = ($urandom_range(0, 3) == 0);
        while (n_load + n_probe > 0)
        begin
            if (n_probe == 0 || (n_load > 0 && (!mixed || $urandom_range(0, 1) == 1)))
            begin
                queue_item(CMD_LOAD, pick_coord(cx), pick_coord(cy), pick_coord(cz));
                n_load--;
            end
            else
            begin
                queue_item(CMD_PROBE, pick_coord(cx), pick_coord(cy), pick_coord(cz));
                n_probe--;
            end
            if ($urandom_range(0, 29) == 0)
                queue_item(CMD_SPARE, pick_coord(cx), pick_coord(cy), pick_coord(cz));
        end
        // a missing finish lets the next set pile onto this one
        if ($urandom_range(0, 11) != 0)
            queue_item(CMD_FINISH, pick_coord('0), pick_coord('0), pick_coord('0));
    endtask

    // stimulus and end of run
    initial
    begin : stimulus
        int saved;
        int n;
        bit fill_done;
        fill_done = 1'b0;

        // finish on empty sets, probe with nothing stored
        queue_item(CMD_FINISH, '0, '0, '0);
        queue_item(CMD_PROBE, '0, '0, '0);
        queue_item(CMD_FINISH, COORD_MAX, COORD_MIN, '0);
        // widest separation
        queue_item(CMD_LOAD, COORD_MAX, COORD_MAX, COORD_MAX);
        queue_item(CMD_PROBE, COORD_MIN, COORD_MIN, COORD_MIN);
        queue_item(CMD_FINISH, '0, '0, '0);
        // exact hit gives zero
        queue_item(CMD_LOAD, COORD_MIN, COORD_MIN, COORD_MIN);
        queue_item(CMD_LOAD, COORD_MAX, COORD_MAX, COORD_MAX);
        queue_item(CMD_PROBE, COORD_MAX, COORD_MAX, COORD_MAX);
        queue_item(CMD_FINISH, '0, '0, '0);
        // equal distances tie, unused command in between
        queue_item(CMD_LOAD, 20'sd256, '0, '0);
        queue_item(CMD_LOAD, -20'sd256, '0, '0);
        queue_item(CMD_PROBE, '0, '0, '0);
        queue_item(CMD_SPARE, COORD_MAX, COORD_MIN, COORD_MAX);
        queue_item(CMD_FINISH, '0, '0, '0);
        // first set only
        queue_item(CMD_LOAD, 20'sd1, -20'sd1, 20'sd1);
        queue_item(CMD_FINISH, '0, '0, '0);
        // later probe improves the minimum
        queue_item(CMD_LOAD, '0, '0, '0);
        queue_item(CMD_PROBE, 20'sd3, 20'sd4, '0);
        queue_item(CMD_PROBE, '0, '0, 20'sd1);
        queue_item(CMD_FINISH, '0, '0, '0);
        queue_pause();

        queued_count = 0;
        while (queued_count < RANDOM_ITEMS)
        begin
            // one set that fills the store and drops loads, kept out of the count
            if (!fill_done && queued_count >= 150)
            begin
                saved = queued_count;
                repeat (MAX_PTS + 6)
                    queue_item(CMD_LOAD, pick_coord('0), pick_coord('0), pick_coord('0));
                repeat (2)
                    queue_item(CMD_PROBE, pick_coord('0), pick_coord('0), pick_coord('0));
                queue_item(CMD_FINISH, '0, '0, '0);
                queued_count = saved;
                fill_done = 1'b1;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                // noise: any command in any order
                n = $urandom_range(1, 8);
                repeat (n)
                    queue_item(CMD_W'($urandom_range(0, 3)),
                               pick_coord('0), pick_coord('0), pick_coord('0));
            end
            else
                queue_random_set();
            if ($urandom_range(0, 19) == 0)
                queue_pause();
        end
        queue_item(CMD_FINISH, '0, '0, '0);

        while (stim_queue.size() != 0 || item_valid)
            @(posedge clk);
        while (pending_distances.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_distances.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // driver: bursts of transfers with random gaps, pause markers wait for results
    always @(posedge clk or negedge rst_n)
    begin : driver
        logic        nxt_valid;
        item_t       nxt_item;
        int unsigned roll;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item <= '0;
        end
        else
        begin
            nxt_valid = item_valid;
            nxt_item = item;
            if (item_valid && !item_stall)
            begin
                predict_distance(item);
                void'(stim_queue.pop_front());
                nxt_valid = 1'b0;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    roll = $urandom_range(0, 9);
                    gap_left = (roll < 4) ? 0 : (roll < 8) ? $urandom_range(1, 3)
                                                            : $urandom_range(4, 12);
                end
            end
            if (!nxt_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (stim_queue.size() != 0)
                begin
                    if (!stim_queue[0].pause)
                    begin
                        nxt_valid = 1'b1;
                        nxt_item = stim_queue[0].payload;
                    end
                    else if (pending_distances.size() == 0)
                        void'(stim_queue.pop_front());
                end
            end
            item_valid <= nxt_valid;
            item <= nxt_item;
        end
    end

    // receiver: stall pattern of its own, plus two long hold-offs
    always @(posedge clk or negedge rst_n)
    begin : receiver
        logic nxt_stall;
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
                rx_seen++;
            if (phase_left <= 0)
            begin
                stall_mode = $urandom_range(0, 3);
                phase_left = $urandom_range(16, 96);
            end
            phase_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                nxt_stall = 1'b1;
            end
            else if (holds_done < 2 && result_valid && rx_seen >= (holds_done == 0 ? 8 : 40))
            begin
                hold_left = LONG_HOLD;
                holds_done++;
                nxt_stall = 1'b1;
            end
            else
            begin
                case (stall_mode)
                    1: nxt_stall = ($urandom_range(0, 1) == 1);
                    2: nxt_stall = ($urandom_range(0, 3) == 0);
                    3: nxt_stall = !result_stall;
                    default: nxt_stall = 1'b0;
                endcase
            end
            result_stall <= nxt_stall;
        end
    end

    // monitor: compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin : monitor
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_distances.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: distance %0d found %0b overflow %0b",
                             result.distance, result.found, result.overflow);
            end
            else
            begin
                want = pending_distances.pop_front();
                if (result.distance !== want.distance || result.found !== want.found ||
                    result.overflow !== want.overflow)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b",
                                 want.distance, want.found, want.overflow,
                                 result.distance, result.found, result.overflow);
                end
            end
        end
    end

    // watchdog: too long without any transfer ends the run
    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: %0d cycles without a transfer", idle_cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

endmodule

>>> files.f
rtl/core/cdps_pkg.sv
rtl/core/cdps_ram.sv
rtl/core/cdps_isqrt.sv
rtl/core/closest_distance_between_point_sets.sv
bench/tb.sv
